### hw/rtl/cfqs_pkg.sv
// Shared types and constants for the continued fraction quotient sum block.
// Holds the sequencer state type, the control and status structs and the field width.
// No dependencies.
`default_nettype none

package cfqs_pkg;

  // Width of the operand and result fields on the ports.
  localparam int unsigned FIELD_W = 63;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALIGN,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic align;
    logic divide;
  } dp_ctrl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic both_gt1;
    logic no_borrow;
    logic k_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/cfqs_datapath.sv
// Operand registers, quotient and running count around one shared subtractor.
// Loads, checks and aligns, and carries out one shift-subtract division step per divide command.
// Depends on cfqs_pkg.
`default_nettype none

module cfqs_datapath #(
  parameter int unsigned DW = 63,
  parameter int unsigned KW = 6
) (
  input  wire logic                clk,
  input  wire logic [DW-1:0]       num_in,
  input  wire logic [DW-1:0]       den_in,
  input  wire cfqs_pkg::dp_ctrl_t  ctrl,
  output cfqs_pkg::dp_stat_t       stat,
  output logic [DW-1:0]            sum,
  output logic                     err
);

  // big holds the dividend (then the partial remainder), small the divisor.
  logic [DW-1:0] big;
  logic [DW-1:0] small_op;
  logic [DW-1:0] q;
  logic [DW-1:0] acc;
  logic [KW-1:0] k;

  logic [DW:0]   sub_b;
  logic [DW+1:0] diff;
  logic          no_borrow;
  logic [DW-1:0] rem_next;
  logic [DW-1:0] q_next;
  logic [DW-1:0] final_sel;
  logic          big_one;
  logic          small_one;
  logic [DW-1:0] add_b;
  logic [DW-1:0] acc_sum;

  // Shared subtractor: compares against the doubled divisor while aligning,
  // and against the divisor itself while dividing.
  assign sub_b     = ctrl.align ? {small_op, 1'b0} : {1'b0, small_op};
  assign diff      = {2'b00, big} - {1'b0, sub_b};
  assign no_borrow = ~diff[DW+1];

  // Restoring step: keep the difference only when it did not go negative.
  assign rem_next = no_borrow ? diff[DW-1:0] : big;
  assign q_next   = {q[DW-2:0], no_borrow};

  // Closing term once one operand has dropped to one or below.
  assign big_one   = (big == DW'(1));
  assign small_one = (small_op == DW'(1));

  always_comb begin
    if (big_one && small_one) begin
      final_sel = DW'(1);
    end else if (small_one) begin
      final_sel = big;
    end else if (big_one) begin
      final_sel = small_op;
    end else begin
      final_sel = '0;
    end
  end

  // One adder for the count, shared by the quotient fold and the closing term.
  assign add_b   = ctrl.divide ? q_next : final_sel;
  assign acc_sum = acc + add_b;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      big      <= num_in;
      small_op <= den_in;
      acc      <= '0;
      err      <= 1'b0;
    end else if (ctrl.check) begin
      q <= '0;
      k <= '0;
      if (!stat.both_gt1) begin
        acc <= acc_sum;
        err <= ~(big_one | small_one);
      end
    end else if (ctrl.align) begin
      // Double the divisor while it still fits under the dividend.
      if (no_borrow) begin
        small_op <= sub_b[DW-1:0];
        k        <= k + KW'(1);
      end
    end else if (ctrl.divide) begin
      if (stat.k_zero) begin
        // Division complete: divisor becomes the dividend, remainder the divisor.
        big      <= small_op;
        small_op <= rem_next;
        acc      <= acc_sum;
      end else begin
        big      <= rem_next;
        small_op <= small_op >> 1;
        k        <= k - KW'(1);
        q        <= q_next;
      end
    end
  end

  assign stat.both_gt1  = (|big[DW-1:1]) & (|small_op[DW-1:1]);
  assign stat.no_borrow = no_borrow;
  assign stat.k_zero    = (k == '0);
  assign sum            = err ? '0 : acc;

endmodule

`default_nettype wire

### hw/rtl/cfqs_ctrl.sv
// Sequencer for the Euclidean loop: load, check, align, divide and hand-off.
// Drives the datapath commands and the input ready.
// Depends on cfqs_pkg.
`default_nettype none

module cfqs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cfqs_pkg::dp_stat_t  stat,
  input  wire logic                out_free,
  output cfqs_pkg::dp_ctrl_t       ctrl,
  output logic                     out_load
);

  cfqs_pkg::state_t state;
  cfqs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfqs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      cfqs_pkg::ST_IDLE: begin
        if (in_valid) state_next = cfqs_pkg::ST_CHECK;
      end
      cfqs_pkg::ST_CHECK: begin
        state_next = stat.both_gt1 ? cfqs_pkg::ST_ALIGN : cfqs_pkg::ST_EMIT;
      end
      cfqs_pkg::ST_ALIGN: begin
        if (!stat.no_borrow) state_next = cfqs_pkg::ST_DIVIDE;
      end
      cfqs_pkg::ST_DIVIDE: begin
        if (stat.k_zero) state_next = cfqs_pkg::ST_CHECK;
      end
      cfqs_pkg::ST_EMIT: begin
        if (out_free) state_next = cfqs_pkg::ST_IDLE;
      end
      default: begin
        state_next = cfqs_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      cfqs_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      cfqs_pkg::ST_CHECK: begin
        ctrl.check = 1'b1;
      end
      cfqs_pkg::ST_ALIGN: begin
        ctrl.align = 1'b1;
      end
      cfqs_pkg::ST_DIVIDE: begin
        ctrl.divide = 1'b1;
      end
      cfqs_pkg::ST_EMIT: begin
        out_load = out_free;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/continued_fraction_quotient_sum_unit.sv
// After the accepting edge an item passes through the check, the align doublings and the
// shift-subtract steps of each Euclidean division in turn, then a last check and the emit
// into the output register.
// Throughput: one item at a time; the next item is taken once the result is in the
// output register, which may still be waiting for the consumer.
// Reset (rst, synchronous, active high) returns the sequencer to idle and empties the
// output register; operand and result registers are not cleared.
// Depends on cfqs_pkg, cfqs_datapath and cfqs_ctrl.
`default_nettype none

module continued_fraction_quotient_sum_unit #(
  parameter int unsigned VALUE_WIDTH = 63
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cfqs_pkg::FIELD_W-1:0]  numerator,
  input  wire logic [cfqs_pkg::FIELD_W-1:0]  denominator,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [cfqs_pkg::FIELD_W-1:0]       quotient_sum,
  output logic                               not_coprime
);

  localparam int unsigned FW = cfqs_pkg::FIELD_W;
  localparam int unsigned DW = (VALUE_WIDTH < FW) ? VALUE_WIDTH : FW;
  localparam int unsigned KW = $clog2(DW);

  cfqs_pkg::dp_ctrl_t ctrl;
  cfqs_pkg::dp_stat_t stat;
  logic [DW-1:0]      sum;
  logic               err;
  logic               out_free;
  logic               out_load;
  logic               u_dp_rem_ok;

  // Datapath, operands truncated to the datapath width.
  cfqs_datapath #(
    .DW (DW),
    .KW (KW)
  ) u_dp (
    .clk    (clk),
    .num_in (numerator[DW-1:0]),
    .den_in (denominator[DW-1:0]),
    .ctrl   (ctrl),
    .stat   (stat),
    .sum    (sum),
    .err    (err)
  );

  cfqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .out_free (out_free),
    .ctrl     (ctrl),
    .out_load (out_load)
  );

  // Output register: holds one finished item until the consumer takes it.
  assign out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      quotient_sum <= FW'(sum);
      not_coprime  <= err;
    end
  end

  // The remainder now in the divisor register lies below the new dividend.
  assign u_dp_rem_ok = (u_dp.small_op < u_dp.big);

  // An accepted item keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again straight after an item");

  // A result flagged as not coprime always carries a zero count.
  a_err_zero_sum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && not_coprime) |-> (quotient_sum == '0))
    else $error("not_coprime result with non-zero quotient_sum");

  // A result is only written into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  // A finished division leaves a remainder below the new dividend.
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (ctrl.divide && stat.k_zero) |=> (u_dp_rem_ok))
    else $error("remainder not below divisor after division");

endmodule

`default_nettype wire
